@@ design/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, sequencer states,
// the command and status structs of the shared multiply/divide unit and defaults.
// No dependencies.
package rau_pkg;

   localparam int FIELD_BITS     = 32;
   localparam int FUNC_BITS      = 3;
   localparam int EXP_BITS       = 5;
   localparam int WORD_BITS_DEF  = 32;
   localparam int MAX_EXP_DEF    = 31;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_POW = 3'd4
   } func_type;

   typedef enum logic {
      MDU_MUL = 1'b0,
      MDU_DIV = 1'b1
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_POW_D,
      ST_POW_N,
      ST_CHECK,
      ST_GCD,
      ST_DIV_N,
      ST_DIV_D,
      ST_OUT
   } rau_state_type;

endpackage

@@ design/rau_mdu.sv @@
// Shared iterative unit: one bit per cycle shift-add multiply (low word) and
// restoring unsigned divide, both through a single adder. Depends on rau_pkg.
module rau_mdu #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::mdu_cmd_type cmd,
   input  logic [WORD_BITS-1:0] opa,
   input  logic [WORD_BITS-1:0] opb,
   output rau_pkg::mdu_sts_type sts,
   output logic [WORD_BITS-1:0] prod_rem,
   output logic [WORD_BITS-1:0] quot
);
   import rau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(W);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   mdu_op_type    op_ff, op_in;

   logic [W:0]    lhs;
   logic [W:0]    rhs;
   logic          cin;
   logic [W+1:0]  sum;
   logic          carry;

   always_comb begin
      if (op_ff == MDU_MUL) begin
         lhs = {1'b0, acc_ff};
         rhs = {1'b0, x_ff};
         cin = 1'b0;
      end else begin
         lhs = {acc_ff, x_ff[W-1]};
         rhs = ~{1'b0, y_ff};
         cin = 1'b1;
      end
      sum   = {1'b0, lhs} + {1'b0, rhs} + (W+2)'(cin);
      carry = sum[W+1];

      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         acc_in  = '0;
         x_in    = opa;
         y_in    = opb;
         cnt_in  = '0;
         busy_in = 1'b1;
         op_in   = cmd.op;
      end else if (busy_ff) begin
         if (op_ff == MDU_MUL) begin
            acc_in = y_ff[0] ? sum[W-1:0] : acc_ff;
            x_in   = {x_ff[W-2:0], 1'b0};
            y_in   = {1'b0, y_ff[W-1:1]};
         end else begin
            acc_in = carry ? sum[W-1:0] : lhs[W-1:0];
            x_in   = {x_ff[W-2:0], carry};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= MDU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign prod_rem = acc_ff;
   assign quot     = x_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("unit finished without running");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff && !done_ff)
      else $error("unit started while still working");

   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0)
      else $error("step count not cleared at start");

endmodule

@@ design/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, operand registers and
// result register around the shared multiply/divide unit. Depends on rau_pkg, rau_mdu.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   request | req_valid/req_ready, req_*    | in
//   result  | rsp_valid/rsp_ready, rsp_*    | out
//
// Add and subtract use three multiplies in the shared unit, multiply and divide
// two, power two per exponent step, then one division per Euclid remainder step
// and two divisions by the gcd. A request is taken only in the idle state; the
// result register lets the next request in while a result still waits. Reset
// is synchronous and clears control.
module rational_arith_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF,
   parameter int MAX_EXP   = rau_pkg::MAX_EXP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rau_pkg::FUNC_BITS-1:0]       req_func,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_den,
   input  logic [rau_pkg::EXP_BITS-1:0]        req_exponent,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_num,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_den,
   output logic                                rsp_err
);
   import rau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int OW = (W < FIELD_BITS) ? W : FIELD_BITS;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (W'(0) - v) : v;
   endfunction

   rau_state_type        state_ff, state_in;
   logic [FUNC_BITS-1:0] func_ff, func_in;
   logic [W-1:0]         an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [W-1:0]         n_ff, n_in, d_ff, d_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [EXP_BITS-1:0]  cnt_ff, cnt_in;
   logic                 go_ff, go_in;
   logic                 err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                 rsp_err_ff, rsp_err_in;

   mdu_cmd_type  cmd;
   mdu_sts_type  sts;
   logic [W-1:0] opa, opb, prod_rem, quot;
   logic         flip;
   logic [W-1:0] fin_n, fin_d;

   rau_mdu #(.WORD_BITS(WORD_BITS)) u_mdu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .opa      (opa),
      .opb      (opb),
      .sts      (sts),
      .prod_rem (prod_rem),
      .quot     (quot)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      cnt_in       = cnt_ff;
      go_in        = go_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_err_in   = rsp_err_ff;
      req_ready    = 1'b0;
      cmd.start    = 1'b0;
      cmd.op       = MDU_MUL;
      opa          = an_ff;
      opb          = bd_ff;

      flip  = n_ff[W-1] & d_ff[W-1];
      fin_n = flip ? (W'(0) - n_ff) : n_ff;
      fin_d = flip ? (W'(0) - d_ff) : d_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_func;
               an_in   = W'(req_a_num);
               ad_in   = W'(req_a_den);
               bn_in   = W'(req_b_num);
               bd_in   = W'(req_b_den);
               err_in  = 1'b0;
               go_in   = 1'b1;
               case (req_func) inside
                  FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                     state_in = ST_MUL_A;
                  end
                  FUNC_POW: begin
                     n_in   = W'(1);
                     d_in   = W'(1);
                     cnt_in = (int'(req_exponent) > MAX_EXP) ? EXP_BITS'(MAX_EXP)
                                                              : req_exponent;
                     state_in = ST_POW_D;
                  end
                  default: begin
                     err_in   = 1'b1;
                     n_in     = '0;
                     d_in     = '0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MUL_A: begin
            cmd.start = go_ff;
            opa       = an_ff;
            opb       = (func_ff == FUNC_MUL) ? bn_ff : bd_ff;
            if (sts.done) begin
               n_in     = prod_rem;
               go_in    = 1'b1;
               state_in = (func_ff == FUNC_ADD || func_ff == FUNC_SUB) ? ST_MUL_B : ST_MUL_C;
            end
         end
         ST_MUL_B: begin
            cmd.start = go_ff;
            opa       = ad_ff;
            opb       = bn_ff;
            if (sts.done) begin
               n_in     = (func_ff == FUNC_SUB) ? (n_ff - prod_rem) : (n_ff + prod_rem);
               go_in    = 1'b1;
               state_in = ST_MUL_C;
            end
         end
         ST_MUL_C: begin
            cmd.start = go_ff;
            opa       = ad_ff;
            opb       = (func_ff == FUNC_DIV) ? bn_ff : bd_ff;
            if (sts.done) begin
               d_in     = prod_rem;
               state_in = ST_CHECK;
            end
         end
         ST_POW_D: begin
            opa = d_ff;
            opb = ad_ff;
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               cmd.start = go_ff;
               if (sts.done) begin
                  d_in     = prod_rem;
                  go_in    = 1'b1;
                  state_in = ST_POW_N;
               end
            end
         end
         ST_POW_N: begin
            cmd.start = go_ff;
            opa       = n_ff;
            opb       = an_ff;
            if (sts.done) begin
               n_in     = prod_rem;
               cnt_in   = cnt_ff - EXP_BITS'(1);
               go_in    = 1'b1;
               state_in = ST_POW_D;
            end
         end
         ST_CHECK: begin
            if (d_ff == '0) begin
               err_in   = 1'b1;
               n_in     = '0;
               state_in = ST_OUT;
            end else begin
               gx_in    = mag(n_ff);
               gy_in    = mag(d_ff);
               go_in    = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            cmd.op = MDU_DIV;
            opa    = gx_ff;
            opb    = gy_ff;
            if (gy_ff == '0) begin
               go_in    = 1'b1;
               state_in = ST_DIV_N;
            end else begin
               cmd.start = go_ff;
               if (sts.done) begin
                  gx_in = gy_ff;
                  gy_in = prod_rem;
                  go_in = 1'b1;
               end
            end
         end
         ST_DIV_N: begin
            cmd.start = go_ff;
            cmd.op    = MDU_DIV;
            opa       = mag(n_ff);
            opb       = gx_ff;
            if (sts.done) begin
               n_in     = n_ff[W-1] ? (W'(0) - quot) : quot;
               go_in    = 1'b1;
               state_in = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            cmd.start = go_ff;
            cmd.op    = MDU_DIV;
            opa       = mag(d_ff);
            opb       = gx_ff;
            if (sts.done) begin
               d_in     = d_ff[W-1] ? (W'(0) - quot) : quot;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = FIELD_BITS'(fin_n[OW-1:0]);
               rsp_den_in   = FIELD_BITS'(fin_d[OW-1:0]);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.start) begin
         go_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      cnt_ff     <= cnt_in;
      err_ff     <= err_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_err     = rsp_err_ff;

   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !sts.busy)
      else $error("shared unit started while busy");

   a_done_not_pending: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> !go_ff)
      else $error("unit result arrived with a start still pending");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_N || state_ff == ST_DIV_D) |-> gx_ff != '0)
      else $error("reduction by a zero gcd");

   a_good_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !err_ff) |-> d_ff != '0)
      else $error("valid result with zero denominator");

endmodule
